[hw/rtl/sale_pkg.sv]
// Shared types and constants for the static array list engine.
// No dependencies; imported by sale_ctrl, sale_dp and the top level.
package sale_pkg;

  localparam int unsigned DefCapacity   = 16;
  localparam int unsigned DefValueWidth = 32;

  typedef enum logic [3:0] {
    KIND_CLEAR     = 4'd0,
    KIND_INS_FIRST = 4'd1,
    KIND_INS_AT    = 4'd2,
    KIND_INS_LAST  = 4'd3,
    KIND_DEL_FIRST = 4'd4,
    KIND_DEL_AT    = 4'd5,
    KIND_DEL_LAST  = 4'd6,
    KIND_SEARCH    = 4'd7,
    KIND_MINMAX    = 4'd8,
    KIND_SORT      = 4'd9,
    KIND_READ      = 4'd10
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2,
    CNT_DEC  = 2'd3
  } cnt_op_e;

  // controller -> datapath command word
  typedef struct packed {
    logic    start;      // new command accepted: load operand, clear results
    status_e st;         // status to load on start
    logic    is_search;
    logic    is_minmax;
    logic    desc;
    logic    rd_en;
    logic    wb_en;      // write back last read data
    logic    ins_wr;     // write operand
    logic    cap_res;    // result <= read data
    logic    scan_en;    // read data valid for search/minmax
    logic    srt_load;   // sort carry <= read data
    logic    srt_step;   // sort compare-and-write
    logic    srt_flush;  // sort carry written to end of pass
    cnt_op_e cnt_op;
  } ctl_t;

endpackage

[hw/rtl/static_array_list_engine_unit.sv]
// Sort runs bubble passes of one element per cycle through the element
// memory. One command at a time: start is taken when busy is low, also in
// the cycle the previous result strobe (done_o) is shown. The receiver
// cannot stall. Reset clears count and control, not memory.
module static_array_list_engine_unit import sale_pkg::*; #(
  parameter int unsigned LIST_CAPACITY = DefCapacity,
  parameter int unsigned VALUE_WIDTH   = DefValueWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         kind_i,
  input  logic [3:0]         position_i,
  input  logic signed [31:0] operand_value_i,
  input  logic               sort_descending_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] result_value_o,
  output logic signed [31:0] max_value_o,
  output logic [3:0]         found_position_o,
  output logic [4:0]         count_after_o,
  output logic               is_empty_o,
  output logic               is_full_o
);

  localparam int unsigned IW = $clog2(LIST_CAPACITY);
  localparam int unsigned CW = $clog2(LIST_CAPACITY + 1);

  ctl_t          ctl;
  logic [IW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] data_idx, count;

  sale_ctrl #(.Capacity(LIST_CAPACITY)) u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .position_i, .sort_descending_i,
    .count_i(count), .ctl_o(ctl), .rd_addr_o(rd_addr), .wr_addr_o(wr_addr),
    .data_idx_o(data_idx), .done_o
  );

  sale_dp #(.Capacity(LIST_CAPACITY), .ValueWidth(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .ctl_i(ctl), .rd_addr_i(rd_addr), .wr_addr_i(wr_addr),
    .data_idx_i(data_idx), .operand_i(operand_value_i), .count_o(count),
    .status_o, .result_o(result_value_o), .max_o(max_value_o),
    .found_o(found_position_o)
  );

  assign count_after_o = 5'(count);
  assign is_empty_o    = count == '0;
  assign is_full_o     = count == CW'(LIST_CAPACITY);

endmodule

[hw/rtl/sale_dp.sv]
// Datapath: element memory, element count, sort carry and result registers.
// Depends on sale_pkg; driven by sale_ctrl through ctl_t.
module sale_dp import sale_pkg::*; #(
  parameter int unsigned Capacity   = DefCapacity,
  parameter int unsigned ValueWidth = DefValueWidth,
  localparam int unsigned IW = $clog2(Capacity),
  localparam int unsigned CW = $clog2(Capacity + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctl_t                ctl_i,
  input  logic [IW-1:0]       rd_addr_i,
  input  logic [IW-1:0]       wr_addr_i,
  input  logic [CW-1:0]       data_idx_i,
  input  logic signed [31:0]  operand_i,
  output logic [CW-1:0]       count_o,
  output logic [2:0]          status_o,
  output logic signed [31:0]  result_o,
  output logic signed [31:0]  max_o,
  output logic [3:0]          found_o
);

  logic signed [ValueWidth-1:0] mem [Capacity];
  logic signed [ValueWidth-1:0] rd_data_q;
  logic signed [ValueWidth-1:0] op_q;
  logic signed [ValueWidth-1:0] carry_q, carry_d;
  logic signed [ValueWidth-1:0] res_q, max_q;
  logic signed [ValueWidth-1:0] wr_data;
  logic [CW-1:0]                count_q, found_q;
  logic                         hit_q;
  status_e                      status_q;
  logic                         wr_en, swap;

  assign swap = ctl_i.desc ? (carry_q < rd_data_q) : (carry_q > rd_data_q);

  always_comb begin
    wr_en   = ctl_i.wb_en | ctl_i.ins_wr | ctl_i.srt_step | ctl_i.srt_flush;
    carry_d = carry_q;
    wr_data = rd_data_q;
    priority if (ctl_i.ins_wr) begin
      wr_data = op_q;
    end else if (ctl_i.srt_step) begin
      wr_data = swap ? rd_data_q : carry_q;
      carry_d = swap ? carry_q : rd_data_q;
    end else if (ctl_i.srt_flush) begin
      wr_data = carry_q;
    end else if (ctl_i.srt_load) begin
      carry_d = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_i] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
    carry_q <= carry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
      hit_q    <= 1'b0;
      res_q    <= '0;
      max_q    <= '0;
      found_q  <= '0;
      op_q     <= '0;
    end else begin
      unique case (ctl_i.cnt_op)
        CNT_CLR: count_q <= '0;
        CNT_INC: count_q <= count_q + 1'b1;
        CNT_DEC: count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
      if (ctl_i.start) begin
        op_q     <= ValueWidth'(operand_i);
        status_q <= ctl_i.st;
        hit_q    <= 1'b0;
        res_q    <= '0;
        max_q    <= '0;
        found_q  <= '0;
      end else begin
        if (ctl_i.cap_res) begin
          res_q <= rd_data_q;
        end
        if (ctl_i.scan_en && ctl_i.is_search && !hit_q && rd_data_q == op_q) begin
          hit_q    <= 1'b1;
          found_q  <= data_idx_i;
          status_q <= ST_OK;
        end
        if (ctl_i.scan_en && ctl_i.is_minmax) begin
          if (data_idx_i == '0 || rd_data_q < res_q) res_q <= rd_data_q;
          if (data_idx_i == '0 || rd_data_q > max_q) max_q <= rd_data_q;
        end
      end
    end
  end

  assign count_o  = count_q;
  assign status_o = status_q;
  assign result_o = 32'(res_q);
  assign max_o    = 32'(max_q);
  assign found_o  = 4'(found_q);

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Capacity)) else $error("count above capacity");
  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_i.wb_en, ctl_i.ins_wr, ctl_i.srt_step, ctl_i.srt_flush}))
    else $error("two memory writers in one cycle");
  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cnt_op == CNT_INC |-> count_q < CW'(Capacity)) else $error("insert into full list");
`endif

endmodule

[hw/rtl/sale_ctrl.sv]
// Controller: command decode, precondition checks and the walk sequencer.
// Depends on sale_pkg; drives sale_dp through ctl_t and address ports.
module sale_ctrl import sale_pkg::*; #(
  parameter int unsigned Capacity = DefCapacity,
  localparam int unsigned IW = $clog2(Capacity),
  localparam int unsigned CW = $clog2(Capacity + 1),
  localparam int unsigned PW = (CW > 4) ? CW : 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [3:0]    kind_i,
  input  logic [3:0]    position_i,
  input  logic          sort_descending_i,
  input  logic [CW-1:0] count_i,
  output ctl_t          ctl_o,
  output logic [IW-1:0] rd_addr_o,
  output logic [IW-1:0] wr_addr_o,
  output logic [CW-1:0] data_idx_o,
  output logic          done_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_SHIFT, S_INS_WRITE, S_DEL_FETCH, S_DEL_SHIFT,
    S_RD_FETCH, S_RD_CAP, S_SCAN, S_SORT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] ptr_q, idx_q, dix_q;
  logic          pend_q, cap_q, done_q, srch_q, mm_q, desc_q;
  logic          acc, full, empty;
  logic [PW-1:0] pos_w, cnt_w;
  logic [CW:0]   ptr_inc;
  status_e       st;

  assign acc     = start && (state_q == S_IDLE);
  assign full    = count_i == CW'(Capacity);
  assign empty   = count_i == '0;
  assign pos_w   = PW'(position_i);
  assign cnt_w   = PW'(count_i);
  assign ptr_inc = {1'b0, ptr_q} + 1'b1;

  always_comb begin
    st = ST_OK;
    unique case (kind_i)
      KIND_INS_FIRST, KIND_INS_LAST: if (full) st = ST_FULL;
      KIND_INS_AT: begin
        if (full) st = ST_FULL;
        else if (pos_w > cnt_w) st = ST_BADIDX;
      end
      KIND_DEL_FIRST, KIND_DEL_LAST, KIND_MINMAX: if (empty) st = ST_EMPTY;
      KIND_DEL_AT, KIND_READ: begin
        if (empty) st = ST_EMPTY;
        else if (pos_w >= cnt_w) st = ST_BADIDX;
      end
      KIND_SEARCH: st = ST_NOTFOUND;
      default: st = ST_OK;
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.start     = acc;
    ctl_o.st        = st;
    ctl_o.is_search = srch_q;
    ctl_o.is_minmax = mm_q;
    ctl_o.desc      = desc_q;
    ctl_o.cnt_op    = CNT_KEEP;
    rd_addr_o       = IW'(ptr_q);
    wr_addr_o       = IW'(dix_q);
    data_idx_o      = dix_q;
    unique case (state_q)
      S_IDLE: if (acc && kind_i == KIND_CLEAR) ctl_o.cnt_op = CNT_CLR;
      S_INS_SHIFT: begin
        ctl_o.rd_en = ptr_q > idx_q;
        rd_addr_o   = IW'(ptr_q - 1'b1);
        ctl_o.wb_en = pend_q;
      end
      S_INS_WRITE: begin
        ctl_o.ins_wr = 1'b1;
        wr_addr_o    = IW'(idx_q);
        ctl_o.cnt_op = CNT_INC;
      end
      S_DEL_FETCH, S_RD_FETCH: begin
        ctl_o.rd_en = 1'b1;
        rd_addr_o   = IW'(idx_q);
      end
      S_DEL_SHIFT: begin
        ctl_o.cap_res = cap_q;
        ctl_o.wb_en   = pend_q;
        ctl_o.rd_en   = ptr_inc < {1'b0, count_i};
        rd_addr_o     = IW'(ptr_inc);
        if (!(ptr_inc < {1'b0, count_i})) ctl_o.cnt_op = CNT_DEC;
      end
      S_RD_CAP: ctl_o.cap_res = 1'b1;
      S_SCAN: begin
        ctl_o.rd_en   = ptr_q < count_i;
        ctl_o.scan_en = pend_q;
      end
      S_SORT: begin
        ctl_o.rd_en = ptr_q <= idx_q;
        if (pend_q) begin
          ctl_o.srt_load = dix_q == '0;
          ctl_o.srt_step = dix_q != '0;
          wr_addr_o      = IW'(dix_q - 1'b1);
        end else if (ptr_q > idx_q) begin
          ctl_o.srt_flush = 1'b1;
          wr_addr_o       = IW'(idx_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      idx_q   <= '0;
      dix_q   <= '0;
      pend_q  <= 1'b0;
      cap_q   <= 1'b0;
      done_q  <= 1'b0;
      srch_q  <= 1'b0;
      mm_q    <= 1'b0;
      desc_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            srch_q <= kind_i == KIND_SEARCH;
            mm_q   <= kind_i == KIND_MINMAX;
            desc_q <= sort_descending_i;
            pend_q <= 1'b0;
            ptr_q  <= '0;
            done_q <= 1'b1;
            if (st == ST_OK || st == ST_NOTFOUND) begin
              unique case (kind_i)
                KIND_INS_FIRST, KIND_INS_AT, KIND_INS_LAST: begin
                  done_q  <= 1'b0;
                  ptr_q   <= count_i;
                  idx_q   <= (kind_i == KIND_INS_FIRST) ? '0 :
                             (kind_i == KIND_INS_LAST) ? count_i : CW'(position_i);
                  state_q <= S_INS_SHIFT;
                end
                KIND_DEL_FIRST, KIND_DEL_AT, KIND_DEL_LAST: begin
                  done_q  <= 1'b0;
                  idx_q   <= (kind_i == KIND_DEL_FIRST) ? '0 :
                             (kind_i == KIND_DEL_LAST) ? count_i - 1'b1 : CW'(position_i);
                  state_q <= S_DEL_FETCH;
                end
                KIND_READ: begin
                  done_q  <= 1'b0;
                  idx_q   <= CW'(position_i);
                  state_q <= S_RD_FETCH;
                end
                KIND_SEARCH, KIND_MINMAX: begin
                  done_q  <= 1'b0;
                  state_q <= S_SCAN;
                end
                KIND_SORT: begin
                  if (count_i > CW'(1)) begin
                    done_q  <= 1'b0;
                    idx_q   <= count_i - 1'b1;
                    state_q <= S_SORT;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_INS_SHIFT: begin
          if (ptr_q > idx_q) begin
            ptr_q  <= ptr_q - 1'b1;
            dix_q  <= ptr_q;
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= S_INS_WRITE;
          end
        end
        S_INS_WRITE: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_DEL_FETCH: begin
          ptr_q   <= idx_q;
          cap_q   <= 1'b1;
          pend_q  <= 1'b0;
          state_q <= S_DEL_SHIFT;
        end
        S_DEL_SHIFT: begin
          cap_q <= 1'b0;
          if (ptr_inc < {1'b0, count_i}) begin
            dix_q  <= ptr_q;
            ptr_q  <= CW'(ptr_inc);
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_RD_FETCH: state_q <= S_RD_CAP;
        S_RD_CAP: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (ptr_q < count_i) begin
            dix_q  <= ptr_q;
            ptr_q  <= ptr_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q  <= 1'b0;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_SORT: begin
          if (ptr_q <= idx_q) begin
            dix_q  <= ptr_q;
            ptr_q  <= ptr_q + 1'b1;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              // end of pass: carry written, shorten the next pass
              ptr_q <= '0;
              if (idx_q == CW'(1)) begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                idx_q <= idx_q - 1'b1;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = state_q != S_IDLE;
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE) else $error("result strobe while busy");
  a_acc_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (busy || done_q)) else $error("accepted word dropped");
  a_ins_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WRITE |=> done_q) else $error("insert did not finish");
  a_del_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEL_SHIFT |-> ptr_q < count_i) else $error("delete walk out of range");
`endif

endmodule
